// ----- rtl/median_of_samples_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for median_of_samples
// Shared property forms used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef MEDIAN_OF_SAMPLES_MACROS_SVH
`define MEDIAN_OF_SAMPLES_MACROS_SVH

// same-cycle implication, off while reset is held
`define MOS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is held
`define MOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also covers the reset cycles
`define MOS_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mos_pkg.sv -----
// ---------------------------------------------------------------------------
// mos_pkg
// Command and status types shared by the controller and the datapath.
// ---------------------------------------------------------------------------
package mos_pkg;

  localparam int SampleW = 64;
  localparam int CountW  = 9;

  // controller -> datapath
  typedef struct packed {
    logic load;      // store one sample or mark it dropped
    logic sel_init;  // start the first rank selection
    logic rd_en;     // read the next store entry
    logic decide;    // settle the current bit, start the next pass
    logic load_out;  // move the median to the output register, empty the set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_rd;      // read issued for the final stored entry
    logic bit_lsb;      // the pass under way settles bit 0
    logic need_second;  // even count, upper middle value still to find
  } sts_t;

endpackage

// ----- rtl/mos_ctrl.sv -----
// ---------------------------------------------------------------------------
// mos_ctrl
// Sequencer: sample load, radix-select passes and result hand-off.
// ---------------------------------------------------------------------------
module mos_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output mos_pkg::cmd_t cmd,
  input  mos_pkg::sts_t sts
);
  import mos_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_READ,
    S_DRAIN,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_tvalid_r;

  always_comb begin
    cmd.load     = (state_r == S_LOAD) && in_tvalid;
    cmd.sel_init = (state_r == S_INIT);
    cmd.rd_en    = (state_r == S_READ);
    cmd.decide   = (state_r == S_DECIDE);
    cmd.load_out = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid && in_tlast) state_nxt = S_INIT;
      end
      S_INIT:  state_nxt = S_READ;
      S_READ: begin
        if (sts.last_rd) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!sts.bit_lsb || sts.need_second) state_nxt = S_READ;
        else state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.load_out) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_tvalid_r;

endmodule

// ----- rtl/mos_dp.sv -----
// ---------------------------------------------------------------------------
// mos_dp
// Sample store, bitwise rank selection and median output register.
// ---------------------------------------------------------------------------
module mos_dp #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mos_pkg::cmd_t                 cmd,
  output mos_pkg::sts_t                 sts,
  input  logic [mos_pkg::SampleW-1:0]   sample,
  output logic [mos_pkg::SampleW-1:0]   median,
  output logic [mos_pkg::CountW-1:0]    sample_count,
  output logic                          overflow
);
  import mos_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_SAMPLES);

  logic [SampleW-1:0] mem [MAX_SAMPLES];

  logic [CW-1:0]      count_r;
  logic               dropped_r;
  logic               full;

  logic [CW-1:0]      idx_r;
  logic               rd_valid_r;
  logic [SampleW-1:0] rd_data_r;
  logic [SampleW-1:0] prefix_r;
  logic [SampleW-1:0] mask_r;
  logic [SampleW-1:0] bit_r;
  logic [CW-1:0]      rank_r;
  logic [CW-1:0]      zeros_r;
  logic               second_r;
  logic [SampleW-1:0] first_r;

  logic [SampleW-1:0] prefix_nxt;
  logic [CW-1:0]      rank_nxt;
  logic [CW-1:0]      rank_lo;
  logic [CW-1:0]      rank_hi;
  logic               match;
  logic [SampleW:0]   pair_sum;
  logic [CW+CountW-1:0] count_ext;

  logic [SampleW-1:0] median_r;
  logic [CountW-1:0]  sample_count_r;
  logic               overflow_r;

  assign full    = (count_r == MaxCount);
  assign rank_lo = (count_r - CW'(1)) >> 1;
  assign rank_hi = count_r >> 1;

  assign sts.last_rd     = (idx_r == count_r - CW'(1));
  assign sts.bit_lsb     = bit_r[0];
  assign sts.need_second = !count_r[0] && !second_r;

  // entry agrees with the settled high bits and has a zero at the current bit
  assign match = (((rd_data_r ^ prefix_r) & mask_r) == '0) && ((rd_data_r & bit_r) == '0);

  always_comb begin
    if (rank_r < zeros_r) begin
      prefix_nxt = prefix_r;
      rank_nxt   = rank_r;
    end else begin
      prefix_nxt = prefix_r | bit_r;
      rank_nxt   = rank_r - zeros_r;
    end
  end

  assign pair_sum  = {1'b0, first_r} + {1'b0, prefix_r};
  assign count_ext = {{CountW{1'b0}}, count_r};

  // store
  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[count_r[AW-1:0]] <= sample;
    if (cmd.rd_en) rd_data_r <= mem[idx_r[AW-1:0]];
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dropped_r  <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      if (cmd.load_out) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end else if (cmd.load) begin
        if (full) dropped_r <= 1'b1;
        else count_r <= count_r + CW'(1);
      end
    end
  end

  // selection
  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      rank_r   <= rank_lo;
      prefix_r <= '0;
      mask_r   <= '0;
      bit_r    <= {1'b1, {(SampleW-1){1'b0}}};
      second_r <= 1'b0;
      idx_r    <= '0;
      zeros_r  <= '0;
    end else if (cmd.decide) begin
      idx_r   <= '0;
      zeros_r <= '0;
      if (bit_r[0] && sts.need_second) begin
        first_r  <= prefix_nxt;
        rank_r   <= rank_hi;
        prefix_r <= '0;
        mask_r   <= '0;
        bit_r    <= {1'b1, {(SampleW-1){1'b0}}};
        second_r <= 1'b1;
      end else begin
        prefix_r <= prefix_nxt;
        rank_r   <= rank_nxt;
        mask_r   <= mask_r | bit_r;
        bit_r    <= bit_r >> 1;
      end
    end else begin
      if (cmd.rd_en) idx_r <= idx_r + CW'(1);
      if (rd_valid_r && match) zeros_r <= zeros_r + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median_r       <= second_r ? pair_sum[SampleW:1] : prefix_r;
      sample_count_r <= count_ext[CountW-1:0];
      overflow_r     <= dropped_r;
    end
  end

  assign median       = median_r;
  assign sample_count = sample_count_r;
  assign overflow     = overflow_r;

endmodule

// ----- rtl/median_of_samples.sv -----
// ---------------------------------------------------------------------------
// median_of_samples
// Median of a set of unsigned 64-bit samples, delivered after the closing beat.
// ---------------------------------------------------------------------------
// Samples stream in one beat per cycle and are written to an on-chip store of
// MAX_SAMPLES entries; once the store is full further samples are dropped and
// the result's overflow flag is set. A beat with tlast closes the set: input
// then stalls while the median is found by a bitwise radix select over the
// store, one entry read per cycle through the store's single read port. Each
// of the 64 bit positions costs one pass over the n stored entries, ending in
// a drain and a decide step. An odd count takes 64 passes and an even count,
// which needs both middle values, takes 128 such passes before the result
// beat is offered. The even-count median is the floor of the mean of the two
// middle values, summed at 65 bits. The result sits in an output register, and
// the block empties and takes new samples as soon as that register is loaded,
// even while the result beat still waits for out_tready. The store needs no
// clearing after reset: only entries written in the current set are read.
// ---------------------------------------------------------------------------
module median_of_samples #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] sample
  input  logic        in_tlast,   // last sample of the set
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [63:0] median, [72:64] sample_count, [79:73] zero
  output logic        out_tuser   // [0] overflow
);
  import mos_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [SampleW-1:0] median;
  logic [CountW-1:0]  sample_count;
  logic               overflow;

  // sequencer: load, selection passes, result hand-off
  mos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // store, rank selection and output register
  mos_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (in_tdata),
    .median       (median),
    .sample_count (sample_count),
    .overflow     (overflow)
  );

  // pack the result beat, pad to whole bytes
  assign out_tdata = {7'b0, sample_count, median};
  assign out_tuser = overflow;

endmodule

// ----- rtl/mos_chk.sv -----
// ---------------------------------------------------------------------------
// mos_chk
// Port-level checks for median_of_samples, attached by bind.
// ---------------------------------------------------------------------------
`include "median_of_samples_macros.svh"

module mos_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // a stalled result beat holds its data
  `MOS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // closing beat stalls input while the median is worked out
  `MOS_ASSERT_NEXT(a_close_stall, in_tvalid && in_tready && in_tlast, !in_tready)

  // byte padding of the result stays zero
  `MOS_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[79:73] == 7'b0)

  // no result beat right after reset
  `MOS_ASSERT_RST(a_rst_quiet, !rst_n, !out_tvalid)

endmodule

bind median_of_samples mos_chk u_mos_chk (.*);

// ----- bench/median_of_samples_tb.sv -----
// ---------------------------------------------------------------------------
// median_of_samples_tb
// Self-checking bench for the streaming median block.
// ---------------------------------------------------------------------------
// Samples go in as beats with random gaps. Each beat that closes a set produces
// one expected median, computed here from a shadow copy of the sample store.
// Result beats are taken with random stalls and compared field by field in
// order. Covered: extreme values, ties, the 65-bit pair sum of even counts,
// a store that fills exactly, a store that overflows (the closing beat
// dropped too), and many random sets of mostly small sizes.
// ---------------------------------------------------------------------------
module median_of_samples_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mos_pkg::*;

  localparam int StoreDepth = 256;
  localparam int TailCycles = 300;

  // value spreads for random samples; tight ones force ties in the select
  typedef enum {
    SPREAD_FULL,
    SPREAD_LOW,
    SPREAD_HIGH,
    SPREAD_ONE_HOT,
    SPREAD_MIXED
  } spread_e;

  typedef struct packed {
    logic [SampleW-1:0] median;
    logic [CountW-1:0]  count;
    logic               overflow;
  } median_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // [63:0] sample
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;   // [63:0] median, [72:64] sample_count, [79:73] zero
  logic        out_tuser;   // [0] overflow

  median_of_samples #(
    .MAX_SAMPLES(StoreDepth)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // shadow of the block's store for the set under way
  logic [SampleW-1:0] held_samples [StoreDepth];
  int                 held_count;
  logic               held_dropped;

  median_result_t     pending_medians [$];

  // pacing switches: when clear, that side runs without gaps
  bit sender_paced;
  bit sink_paced;

  int mismatches;
  int samples_sent;
  int sets_closed;
  int overflow_sets;
  int results_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sort a copy of the held samples and pick the middle, or the floor of the
  // mean of the middle pair summed at 65 bits.
  function automatic median_result_t settle_median();
    logic [SampleW-1:0] sorted [StoreDepth];
    logic [SampleW-1:0] key;
    logic [SampleW:0]   pair_sum;
    median_result_t     r;
    int                 j;
    for (int i = 0; i < held_count; i++) begin
      key = held_samples[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (held_count % 2 == 1) begin
      r.median = sorted[held_count / 2];
    end else begin
      pair_sum = {1'b0, sorted[held_count/2 - 1]} + {1'b0, sorted[held_count/2]};
      r.median = pair_sum[SampleW:1];
    end
    r.count    = CountW'(held_count);
    r.overflow = held_dropped;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] draw_sample(spread_e spread);
    spread_e pick;
    pick = spread;
    if (pick == SPREAD_MIXED) pick = spread_e'($urandom_range(0, 3));
    case (pick)
      SPREAD_LOW:     return SampleW'($urandom_range(0, 7));
      SPREAD_HIGH:    return ~SampleW'($urandom_range(0, 7));
      SPREAD_ONE_HOT: return SampleW'(1) << $urandom_range(0, SampleW - 1);
      default:        return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t ns: result %0d, %s: got 0x%h, want 0x%h",
             $time, results_seen, what, got, want);
  endtask

  // Offer one sample beat; called and left at a falling edge. Hold valid high
  // across back-to-back beats so it is never lowered and raised in one step.
  task automatic send_sample(input logic [SampleW-1:0] value, input logic closes);
    int gap;
    gap = sender_paced ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= closes;
    do @(posedge clk); while (!in_tready);
    // beat accepted: advance the shadow store
    samples_sent++;
    if (held_count < StoreDepth) begin
      held_samples[held_count] = value;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (closes) begin
      pending_medians.push_back(settle_median());
      if (held_dropped) overflow_sets++;
      sets_closed++;
      held_count   = 0;
      held_dropped = 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input spread_e spread);
    for (int i = 0; i < n; i++) send_sample(draw_sample(spread), i == n - 1);
  endtask

  // Hold the input idle until every expected result has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes, ties and the pair sums that need the 65th bit.
  task automatic test_directed_extremes();
    logic [SampleW-1:0] all_ones;
    all_ones     = '1;
    sender_paced = 1'b0;
    sink_paced   = 1'b0;
    send_sample('0, 1'b1);                                 // one zero sample
    send_sample(all_ones, 1'b1);                           // one maximum sample
    send_sample(all_ones, 1'b0);                           // pair sum carries out
    send_sample(all_ones, 1'b1);
    send_sample(all_ones - 1, 1'b0);
    send_sample(all_ones, 1'b1);
    send_sample('0, 1'b0);                                 // full-range pair
    send_sample(all_ones, 1'b1);
    sender_paced = 1'b1;
    sink_paced   = 1'b1;
    send_sample(64'd2, 1'b0);                              // odd pair sum rounds down
    send_sample(64'd1, 1'b1);
    send_sample(64'd5, 1'b0);                              // odd count, unsorted
    send_sample(all_ones, 1'b0);
    send_sample(64'd1, 1'b1);
    send_sample(64'd7, 1'b0);                              // ties in the middle
    send_sample(64'd100, 1'b0);
    send_sample(64'd7, 1'b0);
    send_sample(64'd7, 1'b1);
    send_sample(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);            // alternating bits
    send_sample(64'h5555_5555_5555_5555, 1'b1);
    send_sample(64'h8000_0000_0000_0000, 1'b0);            // top bit decides
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'h8000_0000_0000_0001, 1'b1);
    drain_results();
  endtask

  // Fill the store exactly, then overflow it with the closing beat dropped.
  task automatic test_store_full();
    sender_paced = 1'b0;
    sink_paced   = 1'b1;
    send_set(StoreDepth, SPREAD_MIXED);
    sender_paced = 1'b1;
    send_set(StoreDepth + 3, SPREAD_FULL);
    drain_results();
  endtask

  // Random sets, mostly short, with pacing switched per set.
  task automatic test_random_sets(input int sample_budget);
    int      n;
    int      roll;
    spread_e spread;
    while (samples_sent < sample_budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      n = $urandom_range(1, 6);
      else if (roll < 95) n = $urandom_range(7, 24);
      else                n = $urandom_range(25, 64);
      spread       = spread_e'($urandom_range(0, 4));
      sender_paced = $urandom_range(0, 3) != 0;
      sink_paced   = $urandom_range(0, 3) != 0;
      send_set(n, spread);
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
  endtask

  // Result side: draw a stall per beat, sometimes applied while valid is
  // already up, then take the beat and check it against the oldest median.
  initial begin : result_sink
    median_result_t want;
    int             stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = sink_paced ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 1)) begin
          do @(posedge clk); while (!out_tvalid);
          @(negedge clk);
        end
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      if (pending_medians.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata[63:0], '0);
      end else begin
        want = pending_medians.pop_front();
        if (out_tdata[63:0] !== want.median)
          report_mismatch("median", out_tdata[63:0], want.median);
        if (out_tdata[72:64] !== want.count)
          report_mismatch("sample_count", 64'(out_tdata[72:64]), 64'(want.count));
        if (out_tuser !== want.overflow)
          report_mismatch("overflow", 64'(out_tuser), 64'(want.overflow));
        if (out_tdata[79:73] !== '0)
          report_mismatch("padding", 64'(out_tdata[79:73]), '0);
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    held_count   = 0;
    held_dropped = 1'b0;
    sender_paced = 1'b0;
    sink_paced   = 1'b0;
    mismatches    = 0;
    samples_sent  = 0;
    sets_closed   = 0;
    overflow_sets = 0;
    results_seen  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_store_full();
    test_random_sets(1500);

    // allow time for any stray result beat to show up
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d samples in %0d sets (%0d overflowed); checked %0d results.",
             samples_sent, sets_closed, overflow_sets, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // generous bound: well above the slowest legal run of this stimulus
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results still pending", pending_medians.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
